// ===== src/hhdm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heading hold drive mixer package
// Shared types, constants and small arithmetic helpers for the drive mixer
// and its port checker.
// ----------------------------------------------------------------------------
package hhdm_pkg;

   // Hold mode, as shown on the result channel.
   typedef enum logic [1:0] {
      MODE_OFF   = 2'd0,
      MODE_SERVO = 2'd1,
      MODE_SAME  = 2'd2
   } mode_type;

   // Configuration register indexes.
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CORRECTION_RATIO = 2'd2;

   localparam logic [31:0] PROP_GAIN_RESET        = 32'd671089;
   localparam logic [31:0] DERIV_GAIN_RESET       = 32'd6711;
   localparam logic [15:0] CORRECTION_RATIO_RESET = 16'd19661;

   // Q1.15 limits: deadband edge (0.10), minimum turn cap and full scale.
   localparam logic signed [15:0] DB_LIMIT = 16'sd3276;
   localparam logic        [14:0] MIN_CAP  = 15'd3277;
   localparam logic signed [15:0] FULL_POS = 16'sd32767;

   // Negation that maps the most negative code to full positive scale.
   function automatic logic signed [15:0] neg_sat(input logic signed [15:0] x);
      if (x == -16'sd32768) begin
         return FULL_POS;
      end
      return -x;
   endfunction

   // Values of 0.10 of full scale and below become zero.
   function automatic logic signed [15:0] dead_band(input logic signed [15:0] x);
      if ((x > DB_LIMIT) || (x < -DB_LIMIT)) begin
         return x;
      end
      return 16'sd0;
   endfunction

   // Saturate a side sum to plus or minus full scale.
   function automatic logic signed [15:0] sat_unit(input logic signed [16:0] x);
      if (x > 17'sd32767) begin
         return FULL_POS;
      end
      if (x < -17'sd32767) begin
         return -FULL_POS;
      end
      return x[15:0];
   endfunction

endpackage

// ===== src/heading_hold_drive_mixer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heading hold drive mixer
// Stick shaping, heading hold mode control, PD turn correction and side
// mixing for a two-sided drive.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the result side does not stall,
// and returns one result for each item, passing it through the levels below.
// The four register levels are the input register, the gain products, the
// clamped PD turn term and the result register; each level has its own valid
// bit, so a stalled result only holds back the levels behind it that are full.
// The hold mode and the latched target heading advance as an item leaves the
// input register, so items are handled strictly in order. Gains and the turn
// cap ratio are read live and must only be written while the block is idle.
module heading_hold_drive_mixer_top
   import hhdm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // Input items
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic signed [15:0]   req_stick_forward,
   input  logic signed [15:0]   req_stick_turn,
   input  logic                 req_hold_button,
   input  logic                 req_heading_valid,
   input  logic signed [21:0]   req_heading,
   input  logic signed [15:0]   req_yaw_rate,
   // Result items
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [15:0]   rsp_left_drive,
   output logic signed [15:0]   rsp_right_drive,
   output logic [1:0]           rsp_hold_mode,
   // Configuration writes
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   // Configuration registers
   logic [31:0] prop_gain_ff;
   logic [31:0] deriv_gain_ff;
   logic [15:0] ratio_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= PROP_GAIN_RESET;
         deriv_gain_ff <= DERIV_GAIN_RESET;
         ratio_ff      <= CORRECTION_RATIO_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PROP_GAIN:        prop_gain_ff  <= csr_wdata;
            CSR_DERIV_GAIN:       deriv_gain_ff <= csr_wdata;
            CSR_CORRECTION_RATIO: ratio_ff      <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Stage valid bits and readiness
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   logic s1_ready, s2_ready, s3_ready, out_ready;

   assign out_ready = !out_valid_ff || rsp_ready;
   assign s3_ready  = !s3_valid_ff || out_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_ready)  s1_valid_ff  <= req_valid;
         if (s2_ready)  s2_valid_ff  <= s1_valid_ff;
         if (s3_ready)  s3_valid_ff  <= s2_valid_ff;
         if (out_ready) out_valid_ff <= s3_valid_ff;
      end
   end

   // Input register
   logic signed [15:0] s1_fwd_ff, s1_turn_ff, s1_rate_ff;
   logic               s1_hold_ff, s1_hvalid_ff;
   logic signed [21:0] s1_head_ff;

   always_ff @(posedge clock) begin
      if (s1_ready && req_valid) begin
         s1_fwd_ff    <= req_stick_forward;
         s1_turn_ff   <= req_stick_turn;
         s1_hold_ff   <= req_hold_button;
         s1_hvalid_ff <= req_heading_valid;
         s1_head_ff   <= req_heading;
         s1_rate_ff   <= req_yaw_rate;
      end
   end

   // Hold mode state machine, stepped once per item leaving the input register.
   mode_type           mode_ff, mode_in;
   logic signed [21:0] target_ff, target_in;
   logic               s1_fire;

   assign s1_fire = s1_valid_ff && s2_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_OFF;
         target_ff <= '0;
      end else if (s1_fire) begin
         mode_ff   <= mode_in;
         target_ff <= target_in;
      end
   end

   always_comb begin
      mode_in   = MODE_OFF;
      target_in = target_ff;
      unique case (mode_ff)
         MODE_SERVO: begin
            if (!s1_hold_ff) begin
               mode_in = MODE_OFF;
            end else if (!s1_hvalid_ff) begin
               mode_in = MODE_SAME;
            end else begin
               mode_in = MODE_SERVO;
            end
         end
         MODE_SAME: begin
            mode_in = s1_hold_ff ? MODE_SAME : MODE_OFF;
         end
         default: begin
            if (s1_hold_ff) begin
               if (!s1_hvalid_ff) begin
                  mode_in = MODE_SAME;
               end else begin
                  mode_in   = MODE_SERVO;
                  target_in = s1_head_ff;
               end
            end
         end
      endcase
   end

   // Stick shaping, heading error and gain products
   logic signed [15:0] fwd_db, turn_db;
   logic signed [22:0] head_err;
   logic signed [55:0] prod_p;
   logic signed [48:0] prod_d;
   logic        [14:0] abs_fwd;
   logic        [30:0] cap_prod;

   assign fwd_db   = dead_band(neg_sat(s1_fwd_ff));
   assign turn_db  = dead_band(neg_sat(s1_turn_ff));
   assign head_err = {target_in[21], target_in} - {s1_head_ff[21], s1_head_ff};
   assign prod_p   = head_err * $signed({1'b0, prop_gain_ff});
   assign prod_d   = s1_rate_ff * $signed({1'b0, deriv_gain_ff});
   // The shaped forward axis never reaches -32768, so its magnitude fits 15 bits.
   assign abs_fwd  = fwd_db[15] ? 15'(-fwd_db) : fwd_db[14:0];
   assign cap_prod = abs_fwd * ratio_ff;

   mode_type           s2_mode_ff;
   logic signed [15:0] s2_fwd_ff, s2_turn_ff;
   logic signed [55:0] s2_prod_p_ff;
   logic signed [48:0] s2_prod_d_ff;
   logic        [14:0] s2_cap_ff;

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         s2_mode_ff   <= mode_in;
         s2_fwd_ff    <= fwd_db;
         s2_turn_ff   <= turn_db;
         s2_prod_p_ff <= prod_p;
         s2_prod_d_ff <= prod_d;
         s2_cap_ff    <= cap_prod[30:16];
      end
   end

   // PD term, clamp and conversion to Q1.15
   logic        [14:0] cap;
   logic signed [56:0] pd, lim, pd_clamped;
   logic signed [15:0] turn_pd, turn_sel;

   assign cap = (s2_cap_ff < MIN_CAP) ? MIN_CAP : s2_cap_ff;
   assign lim = $signed({27'd0, cap, 15'd0});
   assign pd  = $signed({s2_prod_p_ff[55], s2_prod_p_ff})
              - $signed({{6{s2_prod_d_ff[48]}}, s2_prod_d_ff, 2'b00});

   always_comb begin
      if (pd > lim) begin
         pd_clamped = lim;
      end else if (pd < -lim) begin
         pd_clamped = -lim;
      end else begin
         pd_clamped = pd;
      end
   end

   // The limit is a whole multiple of 2^15, so flooring the clamped term is
   // just dropping its low bits; it stays within 31 bits.
   assign turn_pd = pd_clamped[30:15];

   always_comb begin
      case (s2_mode_ff)
         MODE_SERVO: turn_sel = turn_pd;
         MODE_SAME:  turn_sel = 16'sd0;
         default:    turn_sel = s2_turn_ff;
      endcase
   end

   mode_type           s3_mode_ff;
   logic signed [15:0] s3_fwd_ff, s3_turn_ff;

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         s3_mode_ff <= s2_mode_ff;
         s3_fwd_ff  <= s2_fwd_ff;
         s3_turn_ff <= turn_sel;
      end
   end

   // Side mixing and result register
   logic signed [16:0] sum_left, sum_right;
   logic signed [15:0] right_sat;

   assign sum_left  = {s3_fwd_ff[15], s3_fwd_ff} - {s3_turn_ff[15], s3_turn_ff};
   assign sum_right = {s3_fwd_ff[15], s3_fwd_ff} + {s3_turn_ff[15], s3_turn_ff};
   assign right_sat = sat_unit(sum_right);

   logic signed [15:0] out_left_ff, out_right_ff;
   mode_type           out_mode_ff;

   always_ff @(posedge clock) begin
      if (out_ready && s3_valid_ff) begin
         out_left_ff  <= sat_unit(sum_left);
         out_right_ff <= -right_sat;
         out_mode_ff  <= s3_mode_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_left_drive  = out_left_ff;
   assign rsp_right_drive = out_right_ff;
   assign rsp_hold_mode   = out_mode_ff;

endmodule

// ===== src/hhdm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heading hold drive mixer port checker
// Port-level properties of the drive mixer, bound to its top level.
// ----------------------------------------------------------------------------
module hhdm_checker
   import hhdm_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic signed [15:0]   rsp_left_drive,
   input logic signed [15:0]   rsp_right_drive,
   input logic [1:0]           rsp_hold_mode
);

   // The pipeline is empty straight after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_ready && !rsp_valid)
      else $error("mixer not empty after reset");

   // The unused mode code never appears on a result.
   a_mode_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hold_mode == MODE_OFF) || (rsp_hold_mode == MODE_SERVO)
                    || (rsp_hold_mode == MODE_SAME))
      else $error("invalid hold mode on result");

   // With the turn forced to zero both sides carry the same throttle.
   a_same_throttle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_hold_mode == MODE_SAME)
         |-> (rsp_left_drive + rsp_right_drive) == 16'sd0)
      else $error("sides differ in same throttle mode");

   // Side commands are saturated to plus or minus full scale.
   a_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_left_drive != -16'sd32768) && (rsp_right_drive != -16'sd32768))
      else $error("side command outside full scale");

   // A stalled item holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left_drive)
         && $stable(rsp_right_drive) && $stable(rsp_hold_mode))
      else $error("stalled result changed");

endmodule

bind heading_hold_drive_mixer_top hhdm_checker u_hhdm_checker (.*);
